@@ rtl/mepwm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the multichannel event PWM scheduler.
// No dependencies; every other file of the block refers to this package by scoped names.

package mepwm_pkg;

   // Default channel count, and the widths of the fixed fields.
   localparam int CHANNELS_DEFAULT = 16;
   localparam int STAMP_W          = 32;
   localparam int PHASE_W          = 24;
   localparam int PAIR_W           = 2 * PHASE_W;

   // Timer constants.
   localparam logic [31:0] NO_EVENT        = 32'h7fff_ffff;
   localparam logic [15:0] MAX_DELTA       = 16'hffff;
   localparam logic [15:0] MIN_DELTA_RESET = 16'd50;

   typedef enum logic [1:0] {
      KIND_TIMER   = 2'd0,
      KIND_ENABLE  = 2'd1,
      KIND_ADJUST  = 2'd2,
      KIND_DISABLE = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [3:0]  channel;
      logic [23:0] on_time;
      logic [23:0] off_time;
   } req_type;

   typedef struct packed {
      logic [15:0] pin_levels;
      logic [15:0] next_delta;
      logic [3:0]  granted_channel;
      logic        status;
      logic        timer_running;
   } rsp_type;

   typedef enum logic [1:0] {
      ALU_ADD = 2'd0,
      ALU_SUB = 2'd1,
      ALU_LTU = 2'd2
   } alu_op_type;

   typedef struct packed {
      alu_op_type  op;
      logic [31:0] a;
      logic [31:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [31:0] result;
      logic        lt;
   } alu_rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_NOW,
      S_LOAD,
      S_DUE,
      S_ADV,
      S_STORE,
      S_MIN,
      S_CLAMP,
      S_FIND,
      S_SYNC,
      S_ADJ,
      S_DIS,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

@@ rtl/multichannel_event_pwm_scheduler.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Top level of the multichannel event PWM scheduler: sequencer, per-channel flags and state.
// Depends on mepwm_pkg, mepwm_alu and mepwm_ram.
//
//   Channel   Ports                     Direction  Handshake
//   ------    ------------------------  ---------  ----------------------------------------
//   request   start, busy, req_word     in         word taken at an edge with start && !busy
//   response  rsp_valid, rsp_word       out        one-cycle strobe, receiver cannot stall
//   config    csr_wr_en, csr_wr_data    in         min_delta written at an edge with csr_wr_en
//
// A timer word advances the time base, then tests each enabled channel, toggling a due
// one, and clamps the smallest interval; with no channel enabled it goes straight to the
// response. An enable word searches for the lowest free channel and, when it claims one,
// sweeps all channels to resynchronize them. Adjust and disable only touch the addressed
// channel. The pace is set by the one shared adder and the single read port of the event
// time memory, which the sequencer visits channel by channel. Busy is high from the
// accepting edge until the strobe cycle, in which the next word may already be taken.
// Synchronous reset returns the sequencer to idle, frees every channel and restores
// min_delta and the programmed interval to 50; the time memories are not cleared.

module multichannel_event_pwm_scheduler #(
   parameter int CHANNELS = mepwm_pkg::CHANNELS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire mepwm_pkg::req_type   req_word,
   output logic                      rsp_valid,
   output mepwm_pkg::rsp_type        rsp_word,
   input  wire logic                 csr_wr_en,
   input  wire logic [15:0]          csr_wr_data
);

   // Channel index width, sweep counter width (it must hold CHANNELS itself) and the
   // address width of the double-buffered phase time memory.
   localparam int CW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CNTW = CW + 1;
   localparam int TAW  = $clog2(2 * CHANNELS);

   mepwm_pkg::state_type state_ff, state_in;
   mepwm_pkg::req_type   req_ff, req_in;
   mepwm_pkg::rsp_type   rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [CNTW-1:0]      cnt_ff, cnt_in;
   logic [CW-1:0]        found_ff, found_in;
   logic                 status_ff, status_in;
   logic [15:0]          min_delta_ff, min_delta_in;
   logic [15:0]          last_delta_ff, last_delta_in;
   logic [31:0]          time_base_ff, time_base_in;
   logic [31:0]          now_ff, now_in;
   logic [31:0]          d_ff, d_in;
   logic [31:0]          best_ff, best_in;

   // Per-channel flags, one flip-flop each.
   logic [CHANNELS-1:0]  en_ff, en_in;
   logic [CHANNELS-1:0]  phase_ff, phase_in;
   logic [CHANNELS-1:0]  sel_ff, sel_in;
   logic [CHANNELS-1:0]  pend_ff, pend_in;
   logic [CHANNELS-1:0]  level_ff, level_in;

   // Memory ports.
   logic                 net_wr_en, net_rd_en;
   logic [CW-1:0]        net_wr_addr;
   logic [31:0]          net_wr_data, net_rd_data;
   logic                 tm_wr_en, tm_rd_en;
   logic [TAW-1:0]       tm_wr_addr, tm_rd_addr;
   logic [mepwm_pkg::PAIR_W-1:0] tm_wr_data, tm_rd_data;

   mepwm_pkg::alu_req_type alu_req;
   mepwm_pkg::alu_rsp_type alu_rsp;

   // Helpers derived from the sweep counter and the latched word.
   logic [CW-1:0]        idx;
   logic                 cnt_end;
   logic                 b_due;
   logic [CW:0]          rd_pair, fnd_pair, adj_pair;
   logic [CW+3:0]        ch_wide;
   logic [CW-1:0]        ch_idx;
   logic                 ch_ok;
   logic [CW+3:0]        found_wide;
   logic [CHANNELS+15:0] level_wide;
   logic [23:0]          t_adv, t_store;
   logic [31:0]          d_clamped;
   logic [31:0]          cand;
   logic                 due;

   assign idx     = cnt_ff[CW-1:0];
   assign cnt_end = (cnt_ff == CNTW'(CHANNELS));

   // The buffer a due channel will use after its toggle: it swaps only when the channel
   // is about to rise and an update is waiting. Known before the event time is read.
   assign b_due   = sel_ff[idx] ^ (phase_ff[idx] & pend_ff[idx]);
   assign rd_pair = {idx, b_due};
   assign tm_rd_addr = rd_pair[TAW-1:0];

   assign ch_wide = {{CW{1'b0}}, req_ff.channel};
   assign ch_idx  = ch_wide[CW-1:0];
   assign ch_ok   = ({28'd0, req_ff.channel} < 32'(CHANNELS));

   assign fnd_pair = {idx, 1'b0};
   assign adj_pair = {ch_idx, ~sel_ff[ch_idx]};

   assign found_wide = {4'd0, found_ff};
   assign level_wide = {16'd0, level_ff};

   // High phase time sits in the upper half of a memory word, low phase time in the lower.
   // During the advance step the phase flag still holds the old value; during the store
   // step it already holds the new one.
   assign t_adv   = phase_ff[idx] ? tm_rd_data[47:24] : tm_rd_data[23:0];
   assign t_store = phase_ff[idx] ? tm_rd_data[23:0] : tm_rd_data[47:24];

   // A channel that is late beyond a whole phase schedules with an interval of zero.
   assign d_clamped = d_ff[31] ? 32'd0 : d_ff;
   assign cand      = alu_rsp.lt ? {16'd0, min_delta_ff} : best_ff;
   assign due       = (alu_rsp.result == 32'd0) || alu_rsp.result[31];

   mepwm_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   // Next event time of each channel.
   mepwm_ram #(
      .DEPTH (CHANNELS),
      .WIDTH (mepwm_pkg::STAMP_W)
   ) u_net_ram (
      .clock   (clock),
      .wr_en   (net_wr_en),
      .wr_addr (net_wr_addr),
      .wr_data (net_wr_data),
      .rd_en   (net_rd_en),
      .rd_addr (idx),
      .rd_data (net_rd_data)
   );

   // High and low phase times, two buffers per channel; the buffer is the low address bit.
   mepwm_ram #(
      .DEPTH (2 * CHANNELS),
      .WIDTH (mepwm_pkg::PAIR_W)
   ) u_time_ram (
      .clock   (clock),
      .wr_en   (tm_wr_en),
      .wr_addr (tm_wr_addr),
      .wr_data (tm_wr_data),
      .rd_en   (tm_rd_en),
      .rd_addr (tm_rd_addr),
      .rd_data (tm_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mepwm_pkg::S_IDLE;
         rsp_valid_ff  <= 1'b0;
         cnt_ff        <= '0;
         found_ff      <= '0;
         status_ff     <= 1'b0;
         min_delta_ff  <= mepwm_pkg::MIN_DELTA_RESET;
         last_delta_ff <= mepwm_pkg::MIN_DELTA_RESET;
         time_base_ff  <= 32'd0;
         en_ff         <= '0;
         phase_ff      <= '0;
         sel_ff        <= '0;
         pend_ff       <= '0;
         level_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         cnt_ff        <= cnt_in;
         found_ff      <= found_in;
         status_ff     <= status_in;
         min_delta_ff  <= min_delta_in;
         last_delta_ff <= last_delta_in;
         time_base_ff  <= time_base_in;
         en_ff         <= en_in;
         phase_ff      <= phase_in;
         sel_ff        <= sel_in;
         pend_ff       <= pend_in;
         level_ff      <= level_in;
      end
   end

   // Working registers and the response word carry no reset.
   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      rsp_ff  <= rsp_in;
      now_ff  <= now_in;
      d_ff    <= d_in;
      best_ff <= best_in;
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = 1'b0;
      cnt_in        = cnt_ff;
      found_in      = found_ff;
      status_in     = status_ff;
      min_delta_in  = csr_wr_en ? csr_wr_data : min_delta_ff;
      last_delta_in = last_delta_ff;
      time_base_in  = time_base_ff;
      now_in        = now_ff;
      d_in          = d_ff;
      best_in       = best_ff;
      en_in         = en_ff;
      phase_in      = phase_ff;
      sel_in        = sel_ff;
      pend_in       = pend_ff;
      level_in      = level_ff;
      net_wr_en     = 1'b0;
      net_wr_addr   = idx;
      net_wr_data   = alu_rsp.result;
      net_rd_en     = 1'b0;
      tm_wr_en      = 1'b0;
      tm_wr_addr    = fnd_pair[TAW-1:0];
      tm_wr_data    = {req_ff.on_time, req_ff.off_time};
      tm_rd_en      = 1'b0;
      alu_req       = '{op: mepwm_pkg::ALU_ADD, a: 32'd0, b: 32'd0};

      unique case (state_ff)
         mepwm_pkg::S_IDLE: begin
            if (start) begin
               req_in    = req_word;
               found_in  = '0;
               status_in = 1'b0;
               cnt_in    = '0;
               unique case (req_word.kind)
                  mepwm_pkg::KIND_TIMER: begin
                     // With every channel free the timer is stopped and nothing changes.
                     state_in = (|en_ff) ? mepwm_pkg::S_NOW : mepwm_pkg::S_DONE;
                  end
                  mepwm_pkg::KIND_ENABLE: begin
                     state_in = mepwm_pkg::S_FIND;
                  end
                  mepwm_pkg::KIND_ADJUST: begin
                     state_in = mepwm_pkg::S_ADJ;
                  end
                  mepwm_pkg::KIND_DISABLE: begin
                     state_in = mepwm_pkg::S_DIS;
                  end
               endcase
            end
         end

         // Advance the time base by the interval that was programmed last.
         mepwm_pkg::S_NOW: begin
            alu_req      = '{op: mepwm_pkg::ALU_ADD, a: time_base_ff,
                             b: {16'd0, last_delta_ff}};
            now_in       = alu_rsp.result;
            time_base_in = alu_rsp.result;
            best_in      = mepwm_pkg::NO_EVENT;
            state_in     = mepwm_pkg::S_LOAD;
         end

         // Walk the channels; an enabled one gets its event time and one phase time buffer fetched.
         mepwm_pkg::S_LOAD: begin
            if (cnt_end) begin
               state_in = mepwm_pkg::S_CLAMP;
            end else if (en_ff[idx]) begin
               net_rd_en = 1'b1;
               tm_rd_en  = 1'b1;
               state_in  = mepwm_pkg::S_DUE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         // Distance to the channel's event; zero or negative means it is due.
         mepwm_pkg::S_DUE: begin
            alu_req  = '{op: mepwm_pkg::ALU_SUB, a: net_rd_data, b: now_ff};
            d_in     = alu_rsp.result;
            state_in = due ? mepwm_pkg::S_ADV : mepwm_pkg::S_MIN;
         end

         // Toggle the channel. A rising edge takes a pending buffer swap with it.
         mepwm_pkg::S_ADV: begin
            alu_req       = '{op: mepwm_pkg::ALU_ADD, a: d_ff, b: {8'd0, t_adv}};
            d_in          = alu_rsp.result;
            phase_in[idx] = ~phase_ff[idx];
            if (phase_ff[idx]) begin
               level_in[idx] = 1'b1;
               if (pend_ff[idx]) begin
                  sel_in[idx]  = ~sel_ff[idx];
                  pend_in[idx] = 1'b0;
               end
            end else begin
               level_in[idx] = 1'b0;
            end
            state_in = mepwm_pkg::S_STORE;
         end

         // The new event time is the old one plus the phase length, so lateness carries on.
         mepwm_pkg::S_STORE: begin
            alu_req   = '{op: mepwm_pkg::ALU_ADD, a: net_rd_data, b: {8'd0, t_store}};
            net_wr_en = 1'b1;
            state_in  = mepwm_pkg::S_MIN;
         end

         mepwm_pkg::S_MIN: begin
            alu_req = '{op: mepwm_pkg::ALU_LTU, a: d_clamped, b: best_ff};
            if (alu_rsp.lt) begin
               best_in = d_clamped;
            end
            cnt_in   = cnt_ff + 1'b1;
            state_in = mepwm_pkg::S_LOAD;
         end

         // Raise the smallest interval to min_delta, then cap it at the 16-bit maximum.
         mepwm_pkg::S_CLAMP: begin
            alu_req       = '{op: mepwm_pkg::ALU_LTU, a: best_ff, b: {16'd0, min_delta_ff}};
            last_delta_in = (|cand[31:16]) ? mepwm_pkg::MAX_DELTA : cand[15:0];
            state_in      = mepwm_pkg::S_DONE;
         end

         // Search for the lowest free channel and claim it with buffer zero.
         mepwm_pkg::S_FIND: begin
            if (cnt_end) begin
               status_in = 1'b1;
               state_in  = mepwm_pkg::S_DONE;
            end else if (!en_ff[idx]) begin
               found_in      = idx;
               tm_wr_en      = 1'b1;
               tm_wr_addr    = fnd_pair[TAW-1:0];
               sel_in[idx]   = 1'b0;
               level_in[idx] = 1'b1;
               pend_in[idx]  = 1'b0;
               en_in[idx]    = 1'b1;
               cnt_in        = '0;
               state_in      = mepwm_pkg::S_SYNC;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         // Resynchronize: every enabled channel rises at the next event, min_delta away.
         mepwm_pkg::S_SYNC: begin
            if (cnt_end) begin
               time_base_in  = 32'd0;
               last_delta_in = min_delta_ff;
               state_in      = mepwm_pkg::S_DONE;
            end else begin
               if (en_ff[idx]) begin
                  phase_in[idx] = 1'b1;
                  net_wr_en     = 1'b1;
                  net_wr_data   = {16'd0, min_delta_ff};
               end
               cnt_in = cnt_ff + 1'b1;
            end
         end

         // New times go to the inactive buffer and wait for the next rising edge.
         mepwm_pkg::S_ADJ: begin
            if (ch_ok) begin
               tm_wr_en        = 1'b1;
               tm_wr_addr      = adj_pair[TAW-1:0];
               pend_in[ch_idx] = 1'b1;
            end
            state_in = mepwm_pkg::S_DONE;
         end

         // Disabling frees the channel but leaves its output level where it is.
         mepwm_pkg::S_DIS: begin
            if (ch_ok) begin
               en_in[ch_idx] = 1'b0;
            end
            state_in = mepwm_pkg::S_DONE;
         end

         mepwm_pkg::S_DONE: begin
            rsp_valid_in           = 1'b1;
            rsp_in.pin_levels      = level_wide[15:0];
            rsp_in.next_delta      = last_delta_ff;
            rsp_in.granted_channel = found_wide[3:0];
            rsp_in.status          = status_ff;
            rsp_in.timer_running   = |en_ff;
            state_in               = mepwm_pkg::S_IDLE;
         end

         default: begin
            state_in = mepwm_pkg::S_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != mepwm_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // A response strobe only ever follows a cycle in which a word was being worked on.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response strobe without a word in progress");

   // Finishing a word always produces exactly its response.
   a_done_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> rsp_valid)
      else $error("word finished without a response");

   // A refused enable means every channel was taken, and nothing was granted.
   a_refused_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.status) |->
         (rsp_word.timer_running && (rsp_word.granted_channel == 4'd0)))
      else $error("enable refused while a channel was free");

   // The channel sweep never runs past the last channel.
   a_sweep_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNTW'(CHANNELS))
      else $error("channel sweep counter out of range");

endmodule

`default_nettype wire

@@ rtl/mepwm_alu.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Shared 32-bit add, subtract and unsigned compare unit of the scheduler.
// Depends on mepwm_pkg for the request and result structs.

module mepwm_alu (
   input  wire mepwm_pkg::alu_req_type alu_req,
   output mepwm_pkg::alu_rsp_type      alu_rsp
);

   logic [32:0] diff;
   logic [31:0] sum;

   // One adder serves subtraction and comparison; the borrow is the compare flag.
   assign diff = {1'b0, alu_req.a} - {1'b0, alu_req.b};
   assign sum  = alu_req.a + alu_req.b;

   always_comb begin
      alu_rsp.lt = diff[32];
      unique case (alu_req.op)
         mepwm_pkg::ALU_ADD: begin
            alu_rsp.result = sum;
         end
         mepwm_pkg::ALU_SUB, mepwm_pkg::ALU_LTU: begin
            alu_rsp.result = diff[31:0];
         end
         default: begin
            alu_rsp.result = sum;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/mepwm_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Simple dual-port memory: one write port, one read port with registered data.
// Depends on mepwm_pkg for its default sizes.

module mepwm_ram #(
   parameter  int DEPTH = mepwm_pkg::CHANNELS_DEFAULT,
   parameter  int WIDTH = mepwm_pkg::STAMP_W,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire  logic             clock,
   input  wire  logic             wr_en,
   input  wire  logic [AW-1:0]    wr_addr,
   input  wire  logic [WIDTH-1:0] wr_data,
   input  wire  logic             rd_en,
   input  wire  logic [AW-1:0]    rd_addr,
   output logic       [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ test/tb_multichannel_event_pwm_scheduler.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the multichannel event PWM scheduler.
// Depends on mepwm_pkg and the multichannel_event_pwm_scheduler top level.
// A queued driver, a response monitor and a built-in predictor check every response word.

module tb_multichannel_event_pwm_scheduler;

   // Cycles without any handshake, while work is outstanding, before the run is abandoned.
   // The limit lies well beyond the slowest word and the short sender gaps.
   localparam int STALL_LIMIT = 3000;
   localparam int NUM_CH      = 16;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                start       = 1'b0;
   logic                busy;
   mepwm_pkg::req_type  req_word    = '0;
   logic                rsp_valid;
   mepwm_pkg::rsp_type  rsp_word;
   logic                csr_wr_en   = 1'b0;
   logic [15:0]         csr_wr_data = '0;

   always #5 clock = ~clock;

   multichannel_event_pwm_scheduler #(
      .CHANNELS(NUM_CH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_valid  (rsp_valid),
      .rsp_word   (rsp_word),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // Request words waiting for the driver, and response words the scheduler owes us.
   mepwm_pkg::req_type pending_words[$];
   mepwm_pkg::rsp_type expected_rsp[$];

   int error_count = 0;
   int idle_pct    = 0;
   int stall_count = 0;

   // Shadow of which channels are claimed, kept by the word generator so that adjust and
   // disable words mostly address live channels. Allocation is always lowest free first.
   logic [NUM_CH-1:0] gen_enabled = '0;

   // ---------------------------------------------------------------------------------------
   // Scheduler predictor: its own copy of the channel table, the timer and min_delta.
   // ---------------------------------------------------------------------------------------
   logic [31:0]       sched_event_at[NUM_CH];
   logic [23:0]       sched_high[2][NUM_CH];
   logic [23:0]       sched_low[2][NUM_CH];
   logic [NUM_CH-1:0] sched_phase;
   logic [NUM_CH-1:0] sched_bank;
   logic [NUM_CH-1:0] sched_swap_due;
   logic [NUM_CH-1:0] sched_enabled;
   logic [NUM_CH-1:0] sched_level;
   logic [31:0]       sched_time_base;
   logic [15:0]       sched_last_delta;
   logic [15:0]       sched_min_gap;

   task automatic reset_scheduler_model();
      for (int i = 0; i < NUM_CH; i++) begin
         sched_event_at[i] = '0;
         sched_high[0][i]  = '0;
         sched_high[1][i]  = '0;
         sched_low[0][i]   = '0;
         sched_low[1][i]   = '0;
      end
      sched_phase      = '0;
      sched_bank       = '0;
      sched_swap_due   = '0;
      sched_enabled    = '0;
      sched_level      = '0;
      sched_time_base  = '0;
      sched_last_delta = mepwm_pkg::MIN_DELTA_RESET;
      sched_min_gap    = mepwm_pkg::MIN_DELTA_RESET;
   endtask

   // Advances the scheduler model by one accepted word and queues the response it owes.
   task automatic predict_response(input mepwm_pkg::req_type w);
      mepwm_pkg::rsp_type r;
      logic [31:0] now;
      logic [31:0] best;
      logic [31:0] d;
      logic [23:0] span;
      int          found;
      r     = '0;
      found = -1;
      case (w.kind)
         mepwm_pkg::KIND_TIMER: begin
            // A stopped timer (nothing enabled) leaves everything untouched.
            if (sched_enabled != '0) begin
               now             = sched_time_base + {16'd0, sched_last_delta};
               sched_time_base = now;
               best            = mepwm_pkg::NO_EVENT;
               for (int i = 0; i < NUM_CH; i++) begin
                  if (sched_enabled[i]) begin
                     d = sched_event_at[i] - now;
                     if (d == 32'd0 || d[31]) begin
                        sched_phase[i] = ~sched_phase[i];
                        if (!sched_phase[i]) begin
                           // Rising edge: a pending adjust takes effect here.
                           sched_level[i] = 1'b1;
                           if (sched_swap_due[i]) begin
                              sched_bank[i]     = ~sched_bank[i];
                              sched_swap_due[i] = 1'b0;
                           end
                        end else begin
                           sched_level[i] = 1'b0;
                        end
                        span = sched_phase[i] ? sched_low[sched_bank[i]][i]
                                              : sched_high[sched_bank[i]][i];
                        d = d + {8'd0, span};
                        sched_event_at[i] = now + d;
                        // Still in the past after a whole phase: schedule as due now.
                        if (d[31])
                           d = 32'd0;
                     end
                     if (d < best)
                        best = d;
                  end
               end
               if (best < {16'd0, sched_min_gap})
                  best = {16'd0, sched_min_gap};
               if (best > {16'd0, mepwm_pkg::MAX_DELTA})
                  best = {16'd0, mepwm_pkg::MAX_DELTA};
               sched_last_delta = best[15:0];
            end
         end
         mepwm_pkg::KIND_ENABLE: begin
            for (int i = 0; i < NUM_CH; i++) begin
               if (found < 0 && !sched_enabled[i])
                  found = i;
            end
            if (found < 0) begin
               r.status = 1'b1;
            end else begin
               sched_high[0][found]  = w.on_time;
               sched_low[0][found]   = w.off_time;
               sched_bank[found]     = 1'b0;
               sched_phase[found]    = 1'b0;
               sched_level[found]    = 1'b1;
               sched_swap_due[found] = 1'b0;
               sched_enabled[found]  = 1'b1;
               // Every live channel restarts so that all go high at the next event.
               for (int i = 0; i < NUM_CH; i++) begin
                  if (sched_enabled[i]) begin
                     sched_phase[i]    = 1'b1;
                     sched_event_at[i] = {16'd0, sched_min_gap};
                  end
               end
               sched_time_base   = '0;
               sched_last_delta  = sched_min_gap;
               r.granted_channel = found[3:0];
            end
         end
         mepwm_pkg::KIND_ADJUST: begin
            // Written into the inactive bank even when the channel is disabled.
            sched_high[~sched_bank[w.channel]][w.channel] = w.on_time;
            sched_low[~sched_bank[w.channel]][w.channel]  = w.off_time;
            sched_swap_due[w.channel]                     = 1'b1;
         end
         default: begin
            // Disable keeps the output level where it was.
            sched_enabled[w.channel] = 1'b0;
         end
      endcase
      r.pin_levels    = sched_level;
      r.next_delta    = sched_last_delta;
      r.timer_running = (sched_enabled != '0);
      expected_rsp.push_back(r);
   endtask

   // ---------------------------------------------------------------------------------------
   // Word generation.
   // ---------------------------------------------------------------------------------------
   task automatic queue_word(input mepwm_pkg::kind_type k, input logic [3:0] ch,
                             input logic [23:0] on_t, input logic [23:0] off_t);
      mepwm_pkg::req_type w;
      logic    placed;
      w.kind     = k;
      w.channel  = ch;
      w.on_time  = on_t;
      w.off_time = off_t;
      pending_words.push_back(w);
      placed = 1'b0;
      if (k == mepwm_pkg::KIND_ENABLE) begin
         for (int i = 0; i < NUM_CH; i++) begin
            if (!placed && !gen_enabled[i]) begin
               gen_enabled[i] = 1'b1;
               placed         = 1'b1;
            end
         end
      end else if (k == mepwm_pkg::KIND_DISABLE) begin
         gen_enabled[ch] = 1'b0;
      end
   endtask

   // Phase lengths: mostly comparable to timer intervals so that channels really toggle,
   // with some long ones and the full 24-bit range now and then.
   function automatic logic [23:0] pick_span();
      int sel;
      sel = $urandom_range(99);
      if (sel < 40)
         return 24'($urandom_range(120));
      else if (sel < 70)
         return 24'($urandom_range(3000));
      else if (sel < 85)
         return 24'($urandom_range(70000));
      else if (sel < 95)
         return 24'($urandom());
      else
         return ($urandom_range(1) != 0) ? 24'hff_ffff : 24'd0;
   endfunction

   // Mostly a live channel, otherwise any channel.
   function automatic logic [3:0] pick_channel();
      logic [3:0] ch;
      ch = 4'($urandom());
      if (gen_enabled != '0 && $urandom_range(99) < 80) begin
         while (!gen_enabled[ch])
            ch = 4'($urandom());
      end
      return ch;
   endfunction

   task automatic queue_random_word();
      int sel;
      sel = $urandom_range(99);
      if (sel < 2) begin
         // Enable burst, long enough to fill the table and then be refused.
         for (int i = 0; i < NUM_CH + 1; i++)
            queue_word(mepwm_pkg::KIND_ENABLE, 4'($urandom()), pick_span(), pick_span());
      end else if (sel < 50) begin
         queue_word(mepwm_pkg::KIND_TIMER, 4'($urandom()), 24'($urandom()),
                    24'($urandom()));
      end else if (sel < 63) begin
         queue_word(mepwm_pkg::KIND_ENABLE, 4'($urandom()), pick_span(), pick_span());
      end else if (sel < 84) begin
         queue_word(mepwm_pkg::KIND_ADJUST, pick_channel(), pick_span(), pick_span());
      end else begin
         queue_word(mepwm_pkg::KIND_DISABLE, pick_channel(), 24'($urandom()),
                    24'($urandom()));
      end
   endtask

   // Returns once the driver has nothing left and every owed response word has arrived.
   // Every word produces a response, so the scheduler is idle at that point.
   task automatic wait_drained();
      do
         @(posedge clock);
      while (pending_words.size() != 0 || start || expected_rsp.size() != 0);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      error_count++;
   endtask

   // ---------------------------------------------------------------------------------------
   // Driver: presents queued request words and holds each one until it is taken.
   // A word is taken at an edge where start is high and busy is low; the predictor sees
   // it at that same edge, using the values both signals had just before the edge.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy)
            predict_response(req_word);
         if (!start || !busy) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
               start    <= 1'b1;
               req_word <= pending_words.pop_front();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Monitor: every strobed response word is compared with the oldest expectation.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      mepwm_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch("unexpected response word", 32'(rsp_word.pin_levels), 32'd0);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_word.pin_levels !== want.pin_levels)
               report_mismatch("pin_levels", 32'(rsp_word.pin_levels),
                               32'(want.pin_levels));
            if (rsp_word.next_delta !== want.next_delta)
               report_mismatch("next_delta", 32'(rsp_word.next_delta),
                               32'(want.next_delta));
            if (rsp_word.granted_channel !== want.granted_channel)
               report_mismatch("granted_channel", 32'(rsp_word.granted_channel),
                               32'(want.granted_channel));
            if (rsp_word.status !== want.status)
               report_mismatch("status", 32'(rsp_word.status), 32'(want.status));
            if (rsp_word.timer_running !== want.timer_running)
               report_mismatch("timer_running", 32'(rsp_word.timer_running),
                               32'(want.timer_running));
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Watchdog: counts cycles with work outstanding but no handshake on either side.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_valid ||
             (pending_words.size() == 0 && expected_rsp.size() == 0 && !start)) begin
            stall_count <= 0;
         end else if (stall_count >= STALL_LIMIT) begin
            $display("[%0t] no handshake for %0d cycles", $realtime, STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end else begin
            stall_count <= stall_count + 1;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus sequence: reset, a directed opening, then random phases with different
   // min_delta settings and sender idle rates.
   // ---------------------------------------------------------------------------------------
   initial begin
      logic [15:0] gap_setting[6];
      int          idle_setting[3];
      int          phase_len;

      gap_setting[0]  = mepwm_pkg::MIN_DELTA_RESET;
      gap_setting[1]  = 16'd1;
      gap_setting[2]  = 16'hffff;
      gap_setting[3]  = 16'd0;         // no lower clamp at all
      gap_setting[4]  = 16'd200;
      gap_setting[5]  = 16'($urandom_range(65535, 1));
      idle_setting[0] = 0;
      idle_setting[1] = 63;
      idle_setting[2] = 21;

      reset_scheduler_model();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed opening, at the reset value of min_delta.
      queue_word(mepwm_pkg::KIND_TIMER,   4'd0,  24'd0,       24'd0);       // timer stopped
      queue_word(mepwm_pkg::KIND_ADJUST,  4'd3,  24'hff_ffff, 24'd0);       // free channel
      queue_word(mepwm_pkg::KIND_DISABLE, 4'd15, 24'd0,       24'd0);       // free channel
      queue_word(mepwm_pkg::KIND_ENABLE,  4'd9,  24'hff_ffff, 24'hff_ffff); // longest phases
      queue_word(mepwm_pkg::KIND_TIMER,   4'd0,  24'd0,       24'd0);
      queue_word(mepwm_pkg::KIND_TIMER,   4'd0,  24'd0,       24'd0);
      queue_word(mepwm_pkg::KIND_ENABLE,  4'd0,  24'd0,       24'd0);       // always late
      queue_word(mepwm_pkg::KIND_TIMER,   4'd0,  24'd0,       24'd0);
      queue_word(mepwm_pkg::KIND_TIMER,   4'd0,  24'd0,       24'd0);
      queue_word(mepwm_pkg::KIND_ENABLE,  4'd0,  24'd100,     24'd37);
      queue_word(mepwm_pkg::KIND_ADJUST,  4'd2,  24'd60,      24'd10);      // next rise
      repeat (4)
         queue_word(mepwm_pkg::KIND_TIMER, 4'd0, 24'd0, 24'd0);
      queue_word(mepwm_pkg::KIND_DISABLE, 4'd0,  24'd0,       24'd0);       // level stays
      queue_word(mepwm_pkg::KIND_TIMER,   4'd0,  24'd0,       24'd0);
      queue_word(mepwm_pkg::KIND_ENABLE,  4'd0,  24'd30,      24'd5000);    // reclaims 0
      queue_word(mepwm_pkg::KIND_ADJUST,  4'd3,  24'd1,       24'd2);       // pending, free
      queue_word(mepwm_pkg::KIND_ENABLE,  4'd0,  24'd80,      24'd80);      // discards it
      repeat (3)
         queue_word(mepwm_pkg::KIND_TIMER, 4'd0, 24'd0, 24'd0);
      queue_word(mepwm_pkg::KIND_DISABLE, 4'd1,  24'd0,       24'd0);
      queue_word(mepwm_pkg::KIND_TIMER,   4'd0,  24'd0,       24'd0);
      wait_drained();

      for (int p = 0; p < 6; p++) begin
         // The scheduler is idle here, so min_delta may change.
         csr_wr_en     <= 1'b1;
         csr_wr_data   <= gap_setting[p];
         sched_min_gap  = gap_setting[p];
         @(posedge clock);
         csr_wr_en <= 1'b0;
         idle_pct   = idle_setting[p % 3];
         phase_len  = 104;
         for (int n = 0; n < phase_len; n++) begin
            queue_random_word();
            // Once, hold the sender back until every owed word is in.
            if (p == 2 && n == phase_len / 2)
               wait_drained();
         end
         wait_drained();
      end

      // Settle, then make sure nothing more shows up.
      repeat (100) @(posedge clock);
      if (expected_rsp.size() != 0)
         report_mismatch("response words never seen", expected_rsp.size(), 0);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
